### rtl/drhe_pkg.sv
// Package for the double round-half-even block.
// Field widths and shared stage types; no dependencies.
`default_nettype none
package drhe_pkg;
  localparam int unsigned WordW = 64;
  localparam int unsigned FracW = 52;
  localparam int unsigned ExpW  = 11;
  localparam int unsigned ShW   = 6;
  localparam logic [ExpW-1:0] ExpMax  = 11'h7FF;
  localparam logic [ExpW-1:0] ExpBias = 11'd1023;
  localparam logic [ExpW-1:0] ExpBig  = 11'd1075;
  localparam logic [WordW-1:0] QuietBit = 64'h0008_0000_0000_0000;
  localparam logic [WordW-1:0] OneBits  = 64'h3FF0_0000_0000_0000;

  // Stage 1 classification output
  typedef struct packed {
    logic             pass;   // result is fixed in byp
    logic [WordW-1:0] byp;
    logic             sign;
    logic [ExpW-1:0]  expo;
    logic [FracW:0]   mant;   // with hidden bit
    logic [ShW-1:0]   sh;     // fraction bits to drop, 1..52
  } s1_t;

  // Stage 2: integer part and round decision
  typedef struct packed {
    logic             pass;
    logic [WordW-1:0] byp;
    logic             sign;
    logic [ExpW-1:0]  expo;
    logic [FracW:0]   ip;
    logic             inc;
    logic [ShW-1:0]   sh;
  } s2_t;
endpackage
`default_nettype wire

### rtl/double_round_half_even.sv
// Round-half-to-even of a binary64 word: top level, three-stage pipeline.
// Depends on drhe_pkg.
//
// Usage: the input channel (value_i, valid_i, stall_o) takes one word per
// cycle while stall_o is low; the output channel (rounded_o, valid_o,
// stall_i) delivers one word per accepted input, in order. An accepted
// word passes through registers s1_q, s2_q and r3_q before valid_o rises;
// the three registered stages are classify, shift and round decision,
// increment and pack. Throughput is one word per cycle unless stalled.
// When stall_i is high the whole pipeline holds, except that bubbles fill:
// stall_o is high only when the output stage holds a word that is stalled
// and every earlier stage is also occupied. No word is lost or repeated.
// Reset (rst_ni low, asynchronous) clears all valid bits; the payload
// registers are not reset. NaN inputs come out with the quiet bit set,
// -0 stays -0, negative values that round to zero give +0.
`default_nettype none
module double_round_half_even (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [63:0] value_i,
  input  wire logic        valid_i,
  output logic             stall_o,
  output logic [63:0]      rounded_o,
  output logic             valid_o,
  input  wire logic        stall_i
);
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  drhe_pkg::s1_t s1_d, s1_q;
  drhe_pkg::s2_t s2_d, s2_q;
  logic [63:0] r3_d, r3_q;

  // Stall chain with bubble collapse
  assign en3 = !v3_q || !stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign stall_o = !en1;

  // Stage 1: classify
  always_comb begin
    logic [10:0] e;
    logic [51:0] f;
    logic [10:0] shw;
    e = value_i[62:52];
    f = value_i[51:0];
    shw = drhe_pkg::ExpBig - e;
    s1_d.pass = 1'b1;
    s1_d.byp  = value_i;
    s1_d.sign = value_i[63];
    s1_d.expo = e;
    s1_d.mant = {1'b1, f};
    s1_d.sh   = shw[5:0];
    if (e == drhe_pkg::ExpMax) begin
      if (f != '0) s1_d.byp = value_i | drhe_pkg::QuietBit;
    end else if (e >= drhe_pkg::ExpBig) begin
      s1_d.byp = value_i;
    end else if (e == '0 && f == '0) begin
      s1_d.byp = value_i;
    end else if (e < drhe_pkg::ExpBias - 11'd1) begin
      s1_d.byp = '0;
    end else if (e == drhe_pkg::ExpBias - 11'd1) begin
      s1_d.byp = (f == '0) ? '0 : ({value_i[63], 63'd0} | drhe_pkg::OneBits);
    end else begin
      s1_d.pass = 1'b0;
    end
  end

  // Stage 2: integer part, dropped bits vs one half
  always_comb begin
    logic [52:0] low, half, lmask;
    logic [52:0] ipv;
    lmask = ~(53'h1F_FFFF_FFFF_FFFF << s1_q.sh);
    low   = s1_q.mant & lmask;
    half  = 53'd1 << (s1_q.sh - 6'd1);
    ipv   = s1_q.mant >> s1_q.sh;
    s2_d.pass = s1_q.pass;
    s2_d.byp  = s1_q.byp;
    s2_d.sign = s1_q.sign;
    s2_d.expo = s1_q.expo;
    s2_d.ip   = ipv;
    s2_d.sh   = s1_q.sh;
    s2_d.inc  = (low > half) || (low == half && ipv[0]);
  end

  // Stage 3: increment, shift back, carry-out
  always_comb begin
    logic [53:0] r;
    logic [10:0] e;
    r = {1'b0, s2_q.ip + {52'd0, s2_q.inc}} << s2_q.sh;
    e = s2_q.expo;
    if (r[53]) begin
      e = e + 11'd1;
      r = 54'd0;
    end
    r3_d = s2_q.pass ? s2_q.byp : {s2_q.sign, e, r[51:0]};
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
    if (en2) s2_q <= s2_d;
    if (en3) r3_q <= r3_d;
  end

  assign rounded_o = r3_q;
  assign valid_o   = v3_q;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(rounded_o))
    else $error("output word changed under stall");
  a_nostall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> !stall_o)
    else $error("stall with empty first stage");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o && !stall_i && v1_q && v2_q |=> v1_q)
    else $error("word lost in stage 1");
`endif
endmodule
`default_nettype wire

### tb/sv/drhe_checker.sv
// Checker for the double round-half-even block: watches both channels,
// predicts each rounded word and compares in order. Depends on drhe_pkg.
`default_nettype none
module drhe_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [63:0] value_i,
  input  wire logic        valid_i,
  input  wire logic        stall_o,
  input  wire logic [63:0] rounded_o,
  input  wire logic        valid_o,
  input  wire logic        stall_i,
  output int               errors_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [drhe_pkg::WordW-1:0] rounded_q[$];
  int errors;

  // bit-level round half to even
  function automatic logic [drhe_pkg::WordW-1:0] round_even(
      input logic [drhe_pkg::WordW-1:0] x);
    logic sgn;
    logic [drhe_pkg::ExpW-1:0] e;
    logic [drhe_pkg::FracW-1:0] f;
    logic [63:0] m, low, half, ip, r;
    int s;
    sgn = x[63];
    e = x[62:52];
    f = x[51:0];
    if (e == drhe_pkg::ExpMax) return (f != 0) ? (x | drhe_pkg::QuietBit) : x;
    if (e >= drhe_pkg::ExpBig) return x;
    if (e == 0 && f == 0) return x;
    if (e < drhe_pkg::ExpBias - 1) return '0;
    if (e == drhe_pkg::ExpBias - 1)
      return (f == 0) ? '0 : ({sgn, 63'b0} | drhe_pkg::OneBits);
    s = int'(drhe_pkg::ExpBig) - int'(e);
    m = {11'b0, 1'b1, f};
    low = m & ((64'd1 << s) - 1);
    half = 64'd1 << (s - 1);
    ip = m >> s;
    if (low > half || (low == half && ip[0])) ip++;
    r = ip << s;
    if (r[53]) begin
      e++;
      r = 64'd1 << 52;
    end
    return {sgn, e, r[51:0]};
  endfunction

  // predict on input words, compare on output words
  always @(posedge clk_i or negedge rst_ni) begin
    logic [drhe_pkg::WordW-1:0] exp_w;
    if (!rst_ni) begin
      rounded_q.delete();
      errors = 0;
    end else begin
      if (valid_i && !stall_o) rounded_q.push_back(round_even(value_i));
      if (valid_o && !stall_i) begin
        if (rounded_q.size() == 0) begin
          $error("unexpected word rounded=%h", rounded_o);
          errors++;
        end else begin
          exp_w = rounded_q.pop_front();
          if (exp_w !== rounded_o) begin
            $error("rounded: expected %h actual %h", exp_w, rounded_o);
            errors++;
          end
        end
      end
    end
  end

  assign errors_o = errors;
  assign pending_o = rounded_q.size();
endmodule
`default_nettype wire

### tb/sv/tb_double_round_half_even.sv
// Testbench top for double_round_half_even: stimulus, stalls and verdict.
// Depends on drhe_pkg, drhe_checker and the block itself.
`default_nettype none
module tb_double_round_half_even;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst_n = 0;
  logic [63:0] value = '0;
  logic valid = 0, stall_rx = 0;
  logic stall_tx, valid_out;
  logic [63:0] rounded;
  int errors, pending;
  bit hold_long = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  double_round_half_even u_top (
    .clk_i(clk), .rst_ni(rst_n), .value_i(value), .valid_i(valid),
    .stall_o(stall_tx), .rounded_o(rounded), .valid_o(valid_out), .stall_i(stall_rx)
  );

  drhe_checker u_chk (
    .clk_i(clk), .rst_ni(rst_n), .value_i(value), .valid_i(valid), .stall_o(stall_tx),
    .rounded_o(rounded), .valid_o(valid_out), .stall_i(stall_rx),
    .errors_o(errors), .pending_o(pending)
  );

  // random word biased toward exponents where rounding matters
  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    logic [10:0] e;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: e = 11'h7FF;
      1: e = 11'h000;
      2: e = 11'(drhe_pkg::ExpBias - 1);
      3: e = 11'($urandom_range(1070, 1080));
      4: e = 11'($urandom_range(0, 2047));
      default: e = 11'($urandom_range(1020, 1076));
    endcase
    w[62:52] = e;
    case ($urandom_range(0, 5))
      0: w[51:0] = w[51:0] & ~((52'd1 << $urandom_range(0, 52)) - 1); // exact/tie shapes
      1: w[51:0] = '1;
      2: w[51:0] = '0;
      default: ;
    endcase
    return w;
  endfunction

  // send one word, holding it until accepted
  task automatic send(input logic [63:0] w);
    value <= w;
    valid <= 1;
    @(posedge clk);
    while (stall_tx) @(posedge clk);
  endtask

  // receiver stall pattern, with one long hold-off
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        stall_rx <= 1;
        repeat (60) @(posedge clk);
        hold_long = 0;
      end
      case ($urandom_range(0, 3))
        0: stall_rx <= 0;
        1: stall_rx <= ($urandom_range(0, 1) == 0);
        2: stall_rx <= ($urandom_range(0, 7) == 0);
        default: stall_rx <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin
    logic [63:0] directed[$];
    int n;
    int gap;
    directed = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                 64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0001,
                 64'hFFF8_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF,
                 64'h3FE0_0000_0000_0000, 64'hBFE0_0000_0000_0000,
                 64'hBFE0_0000_0000_0001, 64'h3FE0_0000_0000_0001,
                 64'h0000_0000_0000_0001, 64'h8000_0000_0000_0001,
                 64'h3FF8_0000_0000_0000, 64'h4004_0000_0000_0000,
                 64'hBFFF_FFFF_FFFF_FFFF, 64'h432F_FFFF_FFFF_FFFF,
                 64'h4330_0000_0000_0001, 64'hC330_0000_0000_0000,
                 64'h432F_FFFF_FFFF_FFFE, 64'h3FF0_0000_0000_0000,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'h4337_FFFF_FFFF_FFFF};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (directed[i]) send(directed[i]);
    n = 0;
    while (n < 1300) begin
      repeat ($urandom_range(1, 30)) begin
        if (n == 400) hold_long = 1;
        send(rand_word());
        n++;
      end
      // no gaps while the receiver holds off, so the pipeline fills
      gap = (n < 400 || n > 500) ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire
